// ===== rtl/rcrb_pkg.sv =====
package rcrb_pkg;

  localparam int unsigned WINDOW = 16;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned SEQ_W  = 64;
  localparam int unsigned LIM_W  = 5;
  localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W  = (LIM_W > CNT_W) ? LIM_W : CNT_W;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LIMIT   = 3'd1,
    ST_NOT_REL_CMD = 3'd2,
    ST_EXHAUSTED   = 3'd3,
    ST_WINDOW      = 3'd4,
    ST_FULL        = 3'd5
  } status_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic scan;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic release_run;
    logic scan_stop;
    logic emit_done;
  } stat_t;

endpackage

// ===== rtl/rcrb_ctrl.sv =====
module rcrb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  rcrb_pkg::stat_t stat_i,
  output rcrb_pkg::ctrl_t cmd_o,
  output logic           busy
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.release_run ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.scan_stop) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.emit_done) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && start;
  assign cmd_o.check   = (state_q == S_CHECK);
  assign cmd_o.scan    = (state_q == S_SCAN);
  assign cmd_o.emit    = (state_q == S_EMIT);

endmodule

// ===== rtl/rcrb_datapath.sv =====
module rcrb_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rcrb_pkg::ctrl_t                 cmd_i,
  output rcrb_pkg::stat_t                 stat_o,
  input  logic                            cfg_valid_i,
  input  logic [rcrb_pkg::LIM_W-1:0]      cfg_window_limit_i,
  input  logic [rcrb_pkg::SEQ_W-1:0]      sequence_req_i,
  input  logic                            is_command_i,
  input  logic                            is_reliable_i,
  input  logic [rcrb_pkg::PAY_W-1:0]      payload_word_i,
  output logic                            result_valid_o,
  output logic [2:0]                      status_o,
  output logic                            delivered_o,
  output logic [rcrb_pkg::SEQ_W-1:0]      out_sequence_o,
  output logic [rcrb_pkg::PAY_W-1:0]      out_payload_o,
  output logic                            last_o,
  output logic [rcrb_pkg::SEQ_W-1:0]      expected_next_o,
  output logic [rcrb_pkg::CNT_W-1:0]      buffered_count_o
);

  localparam int unsigned WINDOW = rcrb_pkg::WINDOW;
  localparam int unsigned SEQ_W  = rcrb_pkg::SEQ_W;
  localparam int unsigned PAY_W  = rcrb_pkg::PAY_W;
  localparam int unsigned LIM_W  = rcrb_pkg::LIM_W;
  localparam int unsigned IDX_W  = rcrb_pkg::IDX_W;
  localparam int unsigned CNT_W  = rcrb_pkg::CNT_W;
  localparam int unsigned CMP_W  = rcrb_pkg::CMP_W;
  localparam int unsigned SUM_W  = IDX_W + 1;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(WINDOW - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

  // configuration and block state
  logic [LIM_W-1:0]  lim_q;
  logic [SEQ_W-1:0]  exp_q;
  logic [IDX_W-1:0]  exp_idx_q;
  logic [WINDOW-1:0] valid_q;
  logic [CNT_W-1:0]  held_q;
  logic [PAY_W-1:0]  mem_q [WINDOW];

  // captured word
  logic [SEQ_W-1:0]  seq_q;
  logic              cmd_q;
  logic              rel_q;
  logic [PAY_W-1:0]  pay_q;

  // scan and emit
  logic [SEQ_W-1:0]  scan_seq_q;
  logic [IDX_W-1:0]  scan_idx_q;
  logic [SEQ_W-1:0]  emit_seq_q;
  logic [IDX_W-1:0]  emit_idx_q;
  logic [CNT_W-1:0]  run_q;
  logic [CNT_W-1:0]  emit_cnt_q;
  logic [PAY_W-1:0]  rd_data_q;
  logic [IDX_W-1:0]  rd_addr;

  // result registers
  logic                   res_vld_q;
  rcrb_pkg::status_e      status_q;
  logic                   dlv_q;
  logic [SEQ_W-1:0]       oseq_q;
  logic [PAY_W-1:0]       opay_q;
  logic                   last_q;
  logic [SEQ_W-1:0]       onext_q;
  logic [CNT_W-1:0]       obuf_q;

  // check logic
  logic [CMP_W-1:0]  limit_c;
  logic [SEQ_W-1:0]  offset_c;
  logic              in_win_c;
  logic [SUM_W-1:0]  slot_sum_c;
  logic [IDX_W-1:0]  slot_idx_c;
  rcrb_pkg::status_e chk_status;
  logic              chk_store;
  logic              chk_release;
  logic              scan_stop_c;
  logic              emit_done_c;
  logic              first_emit_c;

  assign limit_c = (CMP_W'(lim_q) > CMP_W'(WINDOW)) ? CMP_W'(WINDOW) : CMP_W'(lim_q);
  assign offset_c = seq_q - exp_q;
  assign in_win_c = (offset_c != '0) && (offset_c <= SEQ_W'(WINDOW));

  // slot of the arriving word, taken relative to the awaited slot
  assign slot_sum_c = {1'b0, exp_idx_q} + offset_c[SUM_W-1:0];
  assign slot_idx_c = (slot_sum_c >= SUM_W'(WINDOW)) ?
                      IDX_W'(slot_sum_c - SUM_W'(WINDOW)) : slot_sum_c[IDX_W-1:0];

  always_comb begin
    chk_status  = rcrb_pkg::ST_OK;
    chk_store   = 1'b0;
    chk_release = 1'b0;
    priority if (lim_q == '0) begin
      chk_status = rcrb_pkg::ST_BAD_LIMIT;
    end else if (!cmd_q || !rel_q || (seq_q == '0)) begin
      chk_status = rcrb_pkg::ST_NOT_REL_CMD;
    end else if (exp_q == '0) begin
      chk_status = rcrb_pkg::ST_EXHAUSTED;
    end else if (seq_q < exp_q) begin
      // stale, dropped quietly
      chk_status = rcrb_pkg::ST_OK;
    end else if (in_win_c && valid_q[slot_idx_c]) begin
      // duplicate of a held word
      chk_status = rcrb_pkg::ST_OK;
    end else if (offset_c == '0) begin
      chk_release = 1'b1;
    end else if (offset_c > SEQ_W'(limit_c)) begin
      chk_status = rcrb_pkg::ST_WINDOW;
    end else if (CMP_W'(held_q) >= limit_c) begin
      chk_status = rcrb_pkg::ST_FULL;
    end else begin
      chk_store = 1'b1;
    end
  end

  assign scan_stop_c  = (scan_seq_q == '0) || !valid_q[scan_idx_q] ||
                        (run_q == CNT_W'(WINDOW));
  assign emit_done_c  = (emit_cnt_q == run_q);
  assign first_emit_c = (emit_cnt_q == '0);
  assign rd_addr      = first_emit_c ? emit_idx_q : idx_inc(emit_idx_q);

  assign stat_o.release_run = chk_release;
  assign stat_o.scan_stop   = scan_stop_c;
  assign stat_o.emit_done   = emit_done_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q      <= rcrb_pkg::LIMIT_RESET;
      exp_q      <= SEQ_W'(1);
      exp_idx_q  <= IDX_W'(1 % WINDOW);
      valid_q    <= '0;
      held_q     <= '0;
      run_q      <= '0;
      emit_cnt_q <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        lim_q <= cfg_window_limit_i;
      end
      if (cmd_i.check) begin
        if (chk_store) begin
          valid_q[slot_idx_c] <= 1'b1;
          held_q              <= held_q + CNT_W'(1);
        end
        if (chk_release) begin
          run_q <= '0;
        end
      end
      if (cmd_i.scan) begin
        if (scan_stop_c) begin
          // final state is known before the first word goes out
          exp_q      <= scan_seq_q;
          exp_idx_q  <= scan_idx_q;
          held_q     <= (held_q > run_q) ? held_q - run_q : '0;
          emit_cnt_q <= '0;
        end else begin
          run_q <= run_q + CNT_W'(1);
        end
      end
      if (cmd_i.emit) begin
        emit_cnt_q <= emit_cnt_q + CNT_W'(1);
        if (!first_emit_c) begin
          valid_q[emit_idx_q] <= 1'b0;
        end
      end
      res_vld_q <= (cmd_i.check && !chk_release) || cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check && chk_store) begin
      mem_q[slot_idx_c] <= pay_q;
    end
    if (cmd_i.emit) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seq_q <= sequence_req_i;
      cmd_q <= is_command_i;
      rel_q <= is_reliable_i;
      pay_q <= payload_word_i;
    end
    if (cmd_i.check && chk_release) begin
      scan_seq_q <= seq_q + SEQ_W'(1);
      scan_idx_q <= idx_inc(exp_idx_q);
      emit_seq_q <= seq_q + SEQ_W'(1);
      emit_idx_q <= idx_inc(exp_idx_q);
    end
    if (cmd_i.scan && !scan_stop_c) begin
      scan_seq_q <= scan_seq_q + SEQ_W'(1);
      scan_idx_q <= idx_inc(scan_idx_q);
    end
    if (cmd_i.emit && !first_emit_c) begin
      emit_seq_q <= emit_seq_q + SEQ_W'(1);
      emit_idx_q <= idx_inc(emit_idx_q);
    end

    if (cmd_i.check && !chk_release) begin
      status_q <= chk_status;
      dlv_q    <= 1'b0;
      oseq_q   <= '0;
      opay_q   <= '0;
      last_q   <= 1'b1;
      onext_q  <= exp_q;
      obuf_q   <= chk_store ? held_q + CNT_W'(1) : held_q;
    end
    if (cmd_i.emit) begin
      status_q <= rcrb_pkg::ST_OK;
      dlv_q    <= 1'b1;
      oseq_q   <= first_emit_c ? seq_q : emit_seq_q;
      opay_q   <= first_emit_c ? pay_q : rd_data_q;
      last_q   <= emit_done_c;
      onext_q  <= exp_q;
      obuf_q   <= held_q;
    end
  end

  assign result_valid_o   = res_vld_q;
  assign status_o         = status_q;
  assign delivered_o      = dlv_q;
  assign out_sequence_o   = oseq_q;
  assign out_payload_o    = opay_q;
  assign last_o           = last_q;
  assign expected_next_o  = onext_q;
  assign buffered_count_o = obuf_q;

endmodule

// ===== rtl/reliable_command_reorder_buffer.sv =====
// Reorder buffer for reliable command words, released strictly by sequence number.
// Input: a word is taken at a clock edge with start high and busy low; the fields
// sequence_req_i, is_command_i, is_reliable_i and payload_word_i are sampled there.
// Config: cfg_window_limit_i is written when cfg_valid_i is high (cfg_ready_o is
// always high); write it only while busy is low and no result is pending.
// Output: each result shows for one cycle with result_valid_o high; the receiver
// cannot stall, so every result must be taken as it appears.
// Sequence: a word that gives one result (error, stale, duplicate or newly held)
// keeps busy high through its check state; its result is registered there and
// shows as busy falls, and no new word is taken while busy is high.
// A word that releases itself and k held successors walks the valid bits one
// slot a cycle, then reads the payload memory one word a cycle, with busy high
// throughout; its k+1 results come back to back, last_o marks the end.
// Every result of a run already carries the final expected_next_o and
// buffered_count_o.
// Reset: awaited sequence one, nothing held, window limit 16; no clearing pass.
module reliable_command_reorder_buffer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rcrb_pkg::LIM_W-1:0]  cfg_window_limit_i,
  input  logic [rcrb_pkg::SEQ_W-1:0]  sequence_req_i,
  input  logic                        is_command_i,
  input  logic                        is_reliable_i,
  input  logic [rcrb_pkg::PAY_W-1:0]  payload_word_i,
  output logic                        result_valid_o,
  output logic [2:0]                  status_o,
  output logic                        delivered_o,
  output logic [rcrb_pkg::SEQ_W-1:0]  out_sequence_o,
  output logic [rcrb_pkg::PAY_W-1:0]  out_payload_o,
  output logic                        last_o,
  output logic [rcrb_pkg::SEQ_W-1:0]  expected_next_o,
  output logic [rcrb_pkg::CNT_W-1:0]  buffered_count_o
);

  rcrb_pkg::ctrl_t cmd;
  rcrb_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  rcrb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  rcrb_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_window_limit_i (cfg_window_limit_i),
    .sequence_req_i     (sequence_req_i),
    .is_command_i       (is_command_i),
    .is_reliable_i      (is_reliable_i),
    .payload_word_i     (payload_word_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .delivered_o        (delivered_o),
    .out_sequence_o     (out_sequence_o),
    .out_payload_o      (out_payload_o),
    .last_o             (last_o),
    .expected_next_o    (expected_next_o),
    .buffered_count_o   (buffered_count_o)
  );

endmodule

// ===== rtl/rcrb_checker.sv =====
module rcrb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic [2:0]                  status_o,
  input logic                        delivered_o,
  input logic [rcrb_pkg::SEQ_W-1:0]  out_sequence_o,
  input logic                        last_o
);

  localparam int unsigned SEQ_W = rcrb_pkg::SEQ_W;

  // a word that is not delivered always stands alone
  a_single_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !delivered_o |-> last_o)
    else $error("undelivered result without last");

  // errors never carry a message
  a_err_no_dlv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != rcrb_pkg::ST_OK) |-> !delivered_o)
    else $error("error result marked delivered");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // a release run goes out on consecutive cycles
  a_run_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o && delivered_o)
    else $error("release run broken");

  a_run_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && delivered_o && !last_o |=>
      out_sequence_o == $past(out_sequence_o) + SEQ_W'(1))
    else $error("release run out of order");

endmodule

bind reliable_command_reorder_buffer rcrb_checker u_rcrb_checker (.*);

// ===== dv/reorder_checker.sv =====
`timescale 1ns / 100ps
module reorder_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [rcrb_pkg::LIM_W-1:0] cfg_limit_i,
  input  logic [rcrb_pkg::SEQ_W-1:0] sequence_i,
  input  logic                       command_i,
  input  logic                       reliable_i,
  input  logic [rcrb_pkg::PAY_W-1:0] payload_i,
  input  logic                       result_valid_i,
  input  logic [2:0]                 status_i,
  input  logic                       delivered_i,
  input  logic [rcrb_pkg::SEQ_W-1:0] out_sequence_i,
  input  logic [rcrb_pkg::PAY_W-1:0] out_payload_i,
  input  logic                       last_i,
  input  logic [rcrb_pkg::SEQ_W-1:0] expected_next_i,
  input  logic [rcrb_pkg::CNT_W-1:0] buffered_count_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         result_count_o,
  output int                         longest_run_o,
  output logic [rcrb_pkg::SEQ_W-1:0] awaited_o
);

  localparam int unsigned WINDOW = rcrb_pkg::WINDOW;
  localparam int unsigned SEQ_W  = rcrb_pkg::SEQ_W;
  localparam int unsigned PAY_W  = rcrb_pkg::PAY_W;
  localparam int unsigned LIM_W  = rcrb_pkg::LIM_W;
  localparam int unsigned CNT_W  = rcrb_pkg::CNT_W;

  typedef struct packed {
    rcrb_pkg::status_e status;
    logic              delivered;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  pay;
    logic              last;
    logic [SEQ_W-1:0]  next;
    logic [CNT_W-1:0]  count;
  } result_word_t;

  result_word_t      pending_results [$];
  result_word_t      head;
  logic [LIM_W-1:0]  limit_reg;
  logic [SEQ_W-1:0]  awaited_seq;
  logic              slot_held [WINDOW];
  logic [PAY_W-1:0]  slot_pay [WINDOW];
  int unsigned       held_total;

  assign awaited_o = awaited_seq;

  function automatic void push_single(input rcrb_pkg::status_e st);
    result_word_t w;
    w.status    = st;
    w.delivered = 1'b0;
    w.seq       = '0;
    w.pay       = '0;
    w.last      = 1'b1;
    w.next      = awaited_seq;
    w.count     = CNT_W'(held_total);
    pending_results = {pending_results, w};
  endfunction

  function automatic void predict_message(input logic [SEQ_W-1:0] seq, input logic cmd,
                                          input logic rel, input logic [PAY_W-1:0] pay);
    logic [SEQ_W-1:0] offset;
    logic [SEQ_W-1:0] run_seq [WINDOW+1];
    logic [PAY_W-1:0] run_pay [WINDOW+1];
    int unsigned      lim;
    int unsigned      slot;
    int unsigned      n;
    int unsigned      i;
    bit               stop;
    result_word_t     w;
    lim    = (limit_reg < WINDOW) ? limit_reg : WINDOW;
    offset = seq - awaited_seq;
    stop   = 1'b0;
    if (limit_reg == 0) begin
      push_single(rcrb_pkg::ST_BAD_LIMIT);
    end else if (!cmd || !rel || seq == 0) begin
      push_single(rcrb_pkg::ST_NOT_REL_CMD);
    end else if (awaited_seq == 0) begin
      push_single(rcrb_pkg::ST_EXHAUSTED);
    end else if (seq < awaited_seq) begin
      // stale, dropped quietly
      push_single(rcrb_pkg::ST_OK);
    end else if (offset >= 1 && offset <= WINDOW && slot_held[seq % WINDOW]) begin
      push_single(rcrb_pkg::ST_OK);
    end else if (offset > lim) begin
      push_single(rcrb_pkg::ST_WINDOW);
    end else if (offset != 0 && held_total >= lim) begin
      push_single(rcrb_pkg::ST_FULL);
    end else if (offset != 0) begin
      slot_held[seq % WINDOW] = 1'b1;
      slot_pay[seq % WINDOW]  = pay;
      held_total++;
      push_single(rcrb_pkg::ST_OK);
    end else begin
      run_seq[0] = seq;
      run_pay[0] = pay;
      n = 1;
      awaited_seq = awaited_seq + 1'b1;
      // drain held successors until a gap, a full window or the counter wraps
      while (!stop && awaited_seq != 0 && n < WINDOW + 1) begin
        slot = 32'(awaited_seq % WINDOW);
        if (!slot_held[slot]) begin
          stop = 1'b1;
        end else begin
          run_seq[n] = awaited_seq;
          run_pay[n] = slot_pay[slot];
          n++;
          slot_held[slot] = 1'b0;
          if (held_total > 0) held_total--;
          awaited_seq = awaited_seq + 1'b1;
        end
      end
      for (i = 0; i < n; i++) begin
        w.status    = rcrb_pkg::ST_OK;
        w.delivered = 1'b1;
        w.seq       = run_seq[i];
        w.pay       = run_pay[i];
        w.last      = (i == n - 1);
        w.next      = awaited_seq;
        w.count     = CNT_W'(held_total);
        pending_results = {pending_results, w};
      end
      if (int'(n) > longest_run_o) longest_run_o = int'(n);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_reg   = rcrb_pkg::LIMIT_RESET;
      awaited_seq = 1;
      held_total  = 0;
      for (int k = 0; k < WINDOW; k++) slot_held[k] = 1'b0;
      pending_results.delete();
      fail_count_o   = 0;
      result_count_o = 0;
      longest_run_o  = 0;
    end else begin
      // retire the result word first, a new message can only add behind it
      if (result_valid_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d seq 0x%0h",
                 status_i, out_sequence_i);
          fail_count_o++;
        end else begin
          head = pending_results.pop_front();
          check_field("status", head.status, status_i);
          check_field("delivered", head.delivered, delivered_i);
          check_field("out_sequence", head.seq, out_sequence_i);
          check_field("out_payload", head.pay, out_payload_i);
          check_field("last", head.last, last_i);
          check_field("expected_next", head.next, expected_next_i);
          check_field("buffered_count", head.count, buffered_count_i);
          result_count_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) limit_reg = cfg_limit_i;
      if (start_i && !busy_i) predict_message(sequence_i, command_i, reliable_i, payload_i);
    end
    pending_o = pending_results.size();
  end

endmodule

// ===== dv/tb_reliable_command_reorder_buffer.sv =====
`timescale 1ns / 100ps
module tb_reliable_command_reorder_buffer;

  localparam int unsigned WINDOW = rcrb_pkg::WINDOW;
  localparam int unsigned SEQ_W  = rcrb_pkg::SEQ_W;
  localparam int unsigned PAY_W  = rcrb_pkg::PAY_W;
  localparam int unsigned LIM_W  = rcrb_pkg::LIM_W;
  localparam int unsigned CNT_W  = rcrb_pkg::CNT_W;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LIM_W-1:0]  cfg_window_limit_i = '0;
  logic [SEQ_W-1:0]  sequence_req_i = '0;
  logic              is_command_i = 1'b0;
  logic              is_reliable_i = 1'b0;
  logic [PAY_W-1:0]  payload_word_i = '0;
  logic              result_valid_o;
  logic [2:0]        status_o;
  logic              delivered_o;
  logic [SEQ_W-1:0]  out_sequence_o;
  logic [PAY_W-1:0]  out_payload_o;
  logic              last_o;
  logic [SEQ_W-1:0]  expected_next_o;
  logic [CNT_W-1:0]  buffered_count_o;

  int                fail_count;
  int                pending;
  int                result_count;
  int                longest_run;
  logic [SEQ_W-1:0]  awaited;

  int                idle_pct = 0;
  int                sent_total = 0;
  int                limit_writes = 0;
  logic [LIM_W-1:0]  cur_limit = rcrb_pkg::LIMIT_RESET;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  reliable_command_reorder_buffer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_window_limit_i (cfg_window_limit_i),
    .sequence_req_i     (sequence_req_i),
    .is_command_i       (is_command_i),
    .is_reliable_i      (is_reliable_i),
    .payload_word_i     (payload_word_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .delivered_o        (delivered_o),
    .out_sequence_o     (out_sequence_o),
    .out_payload_o      (out_payload_o),
    .last_o             (last_o),
    .expected_next_o    (expected_next_o),
    .buffered_count_o   (buffered_count_o)
  );

  reorder_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_limit_i      (cfg_window_limit_i),
    .sequence_i       (sequence_req_i),
    .command_i        (is_command_i),
    .reliable_i       (is_reliable_i),
    .payload_i        (payload_word_i),
    .result_valid_i   (result_valid_o),
    .status_i         (status_o),
    .delivered_i      (delivered_o),
    .out_sequence_i   (out_sequence_o),
    .out_payload_i    (out_payload_o),
    .last_i           (last_o),
    .expected_next_i  (expected_next_o),
    .buffered_count_i (buffered_count_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .result_count_o   (result_count),
    .longest_run_o    (longest_run),
    .awaited_o        (awaited)
  );

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // start goes low for at least the step after each accept
  task automatic send_message(input logic [SEQ_W-1:0] seq, input logic cmd,
                              input logic rel, input logic [PAY_W-1:0] pay);
    @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start          <= 1'b1;
    sequence_req_i <= seq;
    is_command_i   <= cmd;
    is_reliable_i  <= rel;
    payload_word_i <= pay;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    sent_total++;
  endtask

  task automatic drain();
    do @(negedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    drain();
    @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_window_limit_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_limit = value;
    limit_writes++;
  endtask

  // a run of consecutive sequence numbers from the awaited one, shuffled or reversed
  task automatic send_burst(input bit full_reverse);
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    logic             cmd;
    logic             rel;
    int unsigned      eff;
    int unsigned      k;
    int unsigned      i;
    int unsigned      j;
    int unsigned      r;
    int unsigned      tmp;
    int unsigned      order [WINDOW+1];
    @(negedge clk_i);
    base = awaited;
    eff  = (cur_limit < WINDOW) ? cur_limit : WINDOW;
    k    = full_reverse ? WINDOW + 1 : $urandom_range(eff + 1, 1);
    for (i = 0; i < k; i++) order[i] = full_reverse ? k - 1 - i : i;
    if (!full_reverse) begin
      for (j = k - 1; j > 0; j--) begin
        r        = $urandom_range(j);
        tmp      = order[j];
        order[j] = order[r];
        order[r] = tmp;
      end
    end
    for (i = 0; i < k; i++) begin
      seq = base + order[i];
      cmd = 1'b1;
      rel = 1'b1;
      if (!full_reverse && $urandom_range(99) < 10) begin
        case ($urandom_range(3))
          0: cmd = 1'b0;
          1: rel = 1'b0;
          2: seq = base + eff + 1 + $urandom_range(40);
          default: send_message(seq, 1'b1, 1'b1, $urandom);
        endcase
      end
      send_message(seq, cmd, rel, $urandom);
    end
  endtask

  task automatic send_noise();
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    @(negedge clk_i);
    base = awaited;
    case ($urandom_range(4))
      0: seq = {$urandom, $urandom};
      1: seq = '0;
      2: seq = base - $urandom_range(3);
      3: seq = {SEQ_W{1'b1}} - $urandom_range(3);
      default: seq = base + $urandom_range(WINDOW + 8);
    endcase
    send_message(seq, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
  endtask

  initial begin
    int               phase;
    int               phase_start;
    int               s;
    logic [LIM_W-1:0] pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_message(64'd1, 1'b1, 1'b1, 32'h0000_0000);
    send_message(64'd0, 1'b1, 1'b1, 32'h1234_5678);
    send_message(64'd2, 1'b0, 1'b1, 32'h0000_0001);
    send_message(64'd2, 1'b1, 1'b0, 32'h0000_0002);
    send_message(64'd1, 1'b1, 1'b1, 32'h0000_0003);
    send_message({SEQ_W{1'b1}}, 1'b1, 1'b1, 32'hffff_ffff);
    // far edge of the window, then its duplicate, then one past it
    send_message(64'd18, 1'b1, 1'b1, 32'hffff_ffff);
    send_message(64'd18, 1'b1, 1'b1, 32'h0bad_0bad);
    send_message(64'd19, 1'b1, 1'b1, 32'h0000_0019);
    send_message(64'd12, 1'b1, 1'b1, 32'h0000_000c);
    send_message(64'd13, 1'b1, 1'b1, 32'h0000_000d);
    send_message(64'd14, 1'b1, 1'b1, 32'h0000_000e);
    // lowering the limit below the held count makes the buffer full
    write_limit(3);
    send_message(64'd3, 1'b1, 1'b1, 32'h0000_0003);
    send_message(64'd6, 1'b1, 1'b1, 32'h0000_0006);
    send_message(64'd2, 1'b1, 1'b1, 32'hcafe_0002);
    write_limit(0);
    send_message(64'd3, 1'b1, 1'b1, 32'h0000_0003);
    send_message(64'd0, 1'b0, 1'b0, 32'h0000_0000);
    // limit above the window saturates
    write_limit(31);
    send_message(64'd19, 1'b1, 1'b1, 32'h1900_0019);
    for (s = 11; s >= 4; s--) send_message(SEQ_W'(s), 1'b1, 1'b1, $urandom);
    send_message(64'd3, 1'b1, 1'b1, 32'h0300_0003);

    // whole window held, then the awaited word releases the longest run
    send_burst(1'b1);

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 24 : (phase == 1) ? 78 : 0;
      write_limit((phase == 1) ? LIM_W'($urandom_range(15, 1)) : LIM_W'(16));
      phase_start = sent_total;
      while (sent_total - phase_start < 125) begin
        if ($urandom_range(99) < 20) send_noise();
        else send_burst(1'b0);
        if (cur_limit == 0 || $urandom_range(99) < 15) begin
          case ($urandom_range(9))
            0:       pick = 0;
            1, 2, 3: pick = 16;
            4:       pick = 31;
            5:       pick = 1;
            default: pick = LIM_W'($urandom_range(15, 1));
          endcase
          write_limit(pick);
        end
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("summary: %0d messages sent, %0d result words checked, longest release run %0d",
             sent_total, result_count, longest_run);
    $display("summary: %0d window limit writes, sender idle phases of 24, 78 and 0 percent",
             limit_writes);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rcrb_pkg.sv
rtl/rcrb_ctrl.sv
rtl/rcrb_datapath.sv
rtl/reliable_command_reorder_buffer.sv
rtl/rcrb_checker.sv
dv/reorder_checker.sv
dv/tb_reliable_command_reorder_buffer.sv
